// ===== rtl/assert_macros.svh =====
// Assertion helpers; expect i_clk and i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/brb_pkg.sv =====
`timescale 1ns / 1ps

package brb_pkg;

    localparam int DEPTH    = 1024;
    localparam int AW       = $clog2(DEPTH);
    localparam int LINE_MAX = 64;
    localparam int KW       = $clog2(LINE_MAX);
    localparam int LIM_W    = 11;
    localparam int IDX_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int RW       = ((AW + 1) > LIM_W) ? (AW + 1) : LIM_W;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_LOCK   = 3'd2,
        ACT_UNLOCK = 3'd3,
        ACT_LINE   = 3'd4,
        ACT_CLEAR  = 3'd5
    } t_action;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_POP  = 8'b0000_0100,
        S_SCAN = 8'b0000_1000,
        S_FAIL = 8'b0001_0000,
        S_EMIT = 8'b0010_0000,
        S_NL   = 8'b0100_0000,
        S_CLR  = 8'b1000_0000
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] f_free(input logic [AW-1:0] head,
                                                input logic [AW-1:0] tail);
        logic [AW:0] occ;
        occ = (head >= tail) ? ({1'b0, head} - {1'b0, tail})
                             : ({1'b0, head} + (AW + 1)'(DEPTH) - {1'b0, tail});
        return IDX_W'((AW + 1)'(DEPTH - 1) - occ);
    endfunction

endpackage

// ===== rtl/byte_ring_buffer_with_line_read_core.sv =====
`timescale 1ns / 1ps

// Byte ring buffer of DEPTH slots (one always kept empty) in a single
// synchronous memory with a registered read. One word is worked on at a
// time: push, lock, unlock and unknown actions are accepted, then executed;
// pop adds a memory read after execute unless refused on an empty buffer.
// Read line scans bytes up to the newline or head (one memory read per
// cycle), then emits the stored line bytes (one per cycle while the output
// is free) and the newline; on an empty buffer it fails at execute. Clear
// reports its result at once, then sweeps the memory to zero one slot per
// cycle over all DEPTH (1024) slots without taking input. Output stalls
// hold each step that posts a result; the result register lets the next
// word be accepted while a result waits.
module byte_ring_buffer_with_line_read_core import brb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_action,
    input  logic [BYTE_W-1:0] i_data_in,
    input  logic [LIM_W-1:0]  i_limit,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_ok,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic [IDX_W-1:0]  o_region_start,
    output logic [IDX_W-1:0]  o_region_count,
    output logic [IDX_W-1:0]  o_free_count,
    output logic              o_last
);

    t_state r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [AW-1:0]     r_pend, n_pend;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_eptr, n_eptr;
    logic [AW-1:0]     r_clr, n_clr;
    logic [KW-1:0]     r_k, n_k;
    logic [2:0]        r_act;
    logic [BYTE_W-1:0] r_data;
    logic [LIM_W-1:0]  r_limit;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [BYTE_W-1:0] wdata;
    logic [AW-1:0]     raddr;

    logic              r_ovalid;
    logic              r_ok;
    logic [BYTE_W-1:0] r_byte;
    logic [IDX_W-1:0]  r_rs;
    logic [IDX_W-1:0]  r_rc;
    logic [IDX_W-1:0]  r_free;
    logic              r_last;

    logic              slot_free;
    logic              post;
    logic              p_ok;
    logic [BYTE_W-1:0] p_byte;
    logic [IDX_W-1:0]  p_rs;
    logic [IDX_W-1:0]  p_rc;
    logic              p_last;

    logic [KW-1:0]     cap;
    logic [RW-1:0]     run;
    logic [RW-1:0]     run_end;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_ok           = r_ok;
    assign o_out_byte     = r_byte;
    assign o_region_start = r_rs;
    assign o_region_count = r_rc;
    assign o_free_count   = r_free;
    assign o_last         = r_last;

    assign slot_free = !r_ovalid || i_out_ready;

    // line capacity: min(limit-1, LINE_MAX-1), zero for limit zero
    always_comb begin
        if (r_limit == '0) begin
            cap = '0;
        end else if ((r_limit - 1'b1) > LIM_W'(LINE_MAX - 1)) begin
            cap = KW'(LINE_MAX - 1);
        end else begin
            cap = KW'(r_limit - 1'b1);
        end
    end

    // contiguous run from the tail, capped by limit
    always_comb begin
        if (r_head > r_tail) begin
            run = RW'(r_head) - RW'(r_tail);
        end else begin
            run = RW'(DEPTH) - RW'(r_tail);
        end
        if (run > RW'(r_limit)) begin
            run = RW'(r_limit);
        end
        run_end = RW'(r_tail) + run;
        if (run_end >= RW'(DEPTH)) begin
            run_end = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_pend  = r_pend;
        n_ptr   = r_ptr;
        n_eptr  = r_eptr;
        n_clr   = r_clr;
        n_k     = r_k;
        post    = 1'b0;
        p_ok    = 1'b0;
        p_byte  = '0;
        p_rs    = '0;
        p_rc    = '0;
        p_last  = 1'b1;
        we      = 1'b0;
        waddr   = r_head;
        wdata   = r_data;
        raddr   = r_tail;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_act)
                    ACT_PUSH: begin
                        if (slot_free) begin
                            post    = 1'b1;
                            n_state = S_IDLE;
                            if (f_next(r_head) != r_tail) begin
                                p_ok   = 1'b1;
                                we     = 1'b1;
                                n_head = f_next(r_head);
                            end
                        end
                    end
                    ACT_POP: begin
                        if (r_head == r_tail) begin
                            if (slot_free) begin
                                post    = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_state = S_POP;
                        end
                    end
                    ACT_LOCK: begin
                        if (slot_free) begin
                            post    = 1'b1;
                            n_state = S_IDLE;
                            if (r_head != r_tail) begin
                                p_ok   = 1'b1;
                                p_rs   = IDX_W'(r_tail);
                                p_rc   = IDX_W'(run);
                                n_pend = AW'(run_end);
                            end
                        end
                    end
                    ACT_UNLOCK: begin
                        if (slot_free) begin
                            post    = 1'b1;
                            p_ok    = 1'b1;
                            n_tail  = r_pend;
                            n_state = S_IDLE;
                        end
                    end
                    ACT_LINE: begin
                        if (r_head == r_tail) begin
                            if (slot_free) begin
                                post    = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_ptr   = r_tail;
                            n_k     = '0;
                            n_state = S_SCAN;
                        end
                    end
                    ACT_CLEAR: begin
                        if (slot_free) begin
                            post    = 1'b1;
                            p_ok    = 1'b1;
                            n_head  = '0;
                            n_tail  = '0;
                            n_pend  = '0;
                            n_clr   = '0;
                            n_state = S_CLR;
                        end
                    end
                    default: begin
                        if (slot_free) begin
                            post    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP: begin
                if (slot_free) begin
                    post    = 1'b1;
                    p_ok    = 1'b1;
                    p_byte  = r_rdata;
                    n_tail  = f_next(r_tail);
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                raddr = r_ptr;
                if (r_rdata == NEWLINE) begin
                    n_tail  = f_next(r_ptr);
                    n_eptr  = r_tail;
                    raddr   = r_tail;
                    n_state = (r_k == '0) ? S_NL : S_EMIT;
                end else begin
                    if (r_k < cap) begin
                        n_k = r_k + 1'b1;
                    end
                    if (f_next(r_ptr) == r_head) begin
                        n_state = S_FAIL;
                    end else begin
                        n_ptr = f_next(r_ptr);
                        raddr = f_next(r_ptr);
                    end
                end
            end
            S_FAIL: begin
                if (slot_free) begin
                    post    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                raddr = r_eptr;
                if (slot_free) begin
                    post   = 1'b1;
                    p_ok   = 1'b1;
                    p_byte = r_rdata;
                    p_last = 1'b0;
                    n_eptr = f_next(r_eptr);
                    raddr  = f_next(r_eptr);
                    n_k    = r_k - 1'b1;
                    if (r_k == KW'(1)) begin
                        n_state = S_NL;
                    end
                end
            end
            S_NL: begin
                if (slot_free) begin
                    post    = 1'b1;
                    p_ok    = 1'b1;
                    p_byte  = NEWLINE;
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_pend  <= n_pend;
            if (post) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_eptr <= n_eptr;
        r_clr  <= n_clr;
        r_k    <= n_k;
        if (o_in_ready && i_in_valid) begin
            r_act   <= i_action;
            r_data  <= i_data_in;
            r_limit <= i_limit;
        end
        if (post) begin
            r_ok   <= p_ok;
            r_byte <= p_byte;
            r_rs   <= p_rs;
            r_rc   <= p_rc;
            r_free <= f_free(n_head, n_tail);
            r_last <= p_last;
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_push_nonempty, (r_state == S_EXEC) && (r_act == ACT_PUSH) && slot_free, r_head != r_tail)
    `ASSERT_NOW(a_emit_count, r_state == S_EMIT, r_k != '0)
    `ASSERT_NOW(a_only_last_fails, o_out_valid && !o_last, o_ok)
    `ASSERT_NOW(a_clr_indices, r_state == S_CLR, (r_head == '0) && (r_tail == '0))
    `ASSERT_NEXT(a_line_consumes, (r_state == S_SCAN) && (r_rdata == NEWLINE), r_tail == f_next($past(r_ptr)))

endmodule

// ===== tb/tb_byte_ring_buffer_with_line_read_core.sv =====
`timescale 1ns / 1ps

module tb_byte_ring_buffer_with_line_read_core;
    import brb_pkg::*;

    localparam int PLAN = 0;
    localparam int LIVE = 1;
    localparam int WATCHDOG = 8000;
    localparam int RANDOM_WORDS = 230;
    localparam logic [2:0] ACT_BAD_A = 3'd6;
    localparam logic [2:0] ACT_BAD_B = 3'd7;

    typedef struct packed {
        logic [2:0]        action;
        logic [BYTE_W-1:0] data;
        logic [LIM_W-1:0]  limit;
        logic              settle;
        logic              steady;
    } t_ring_word;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] out_byte;
        logic [IDX_W-1:0]  region_start;
        logic [IDX_W-1:0]  region_count;
        logic [IDX_W-1:0]  free_count;
        logic              last;
    } t_ring_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [2:0]        i_action = '0;
    logic [BYTE_W-1:0] i_data_in = '0;
    logic [LIM_W-1:0]  i_limit = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_ok;
    logic [BYTE_W-1:0] o_out_byte;
    logic [IDX_W-1:0]  o_region_start;
    logic [IDX_W-1:0]  o_region_count;
    logic [IDX_W-1:0]  o_free_count;
    logic              o_last;

    byte_ring_buffer_with_line_read_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_data_in      (i_data_in),
        .i_limit        (i_limit),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_out_byte     (o_out_byte),
        .o_region_start (o_region_start),
        .o_region_count (o_region_count),
        .o_free_count   (o_free_count),
        .o_last         (o_last)
    );

    // two copies of the ring: one steers stimulus, one tracks accepted words
    logic [BYTE_W-1:0] ring_mem  [0:1][0:DEPTH-1];
    logic [AW-1:0]     ring_head [0:1];
    logic [AW-1:0]     ring_tail [0:1];
    logic [AW-1:0]     ring_pend [0:1];

    t_ring_word   word_q[$];
    t_ring_result expected_q[$];
    t_ring_word   cur_word;
    t_ring_result want;
    int           error_count = 0;
    int           results_seen = 0;
    int           stall_left = 0;
    bit           stall_done = 1'b0;
    int           stuck_cycles = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        error_count++;
        if (error_count <= 40)
            $display("mismatch: %s at word %0d: got %0d expected %0d",
                     what, results_seen, got, exp_v);
    endtask

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_free(input int s);
        logic [AW-1:0] occ;
        occ = ring_head[s] - ring_tail[s];
        return IDX_W'(DEPTH - 1) - IDX_W'(occ);
    endfunction

    // unlock must not pull the tail over slots that hold no pushed data
    function automatic bit unlock_safe();
        logic [AW-1:0] span;
        logic [AW-1:0] ahead;
        span  = ring_head[PLAN] - ring_tail[PLAN];
        ahead = ring_pend[PLAN] - ring_tail[PLAN];
        return ahead <= span;
    endfunction

    function automatic logic [BYTE_W-1:0] line_byte(input int odds);
        if ($urandom_range(odds - 1) == 0)
            return NEWLINE;
        return BYTE_W'($urandom_range(255));
    endfunction

    task automatic ring_clear(input int s);
        int j;
        for (j = 0; j < DEPTH; j++)
            ring_mem[s][j] = '0;
        ring_head[s] = '0;
        ring_tail[s] = '0;
        ring_pend[s] = '0;
    endtask

    task automatic ring_note(input int s, input logic ok, input logic [BYTE_W-1:0] b,
                             input logic [IDX_W-1:0] rs, input logic [IDX_W-1:0] rc,
                             input logic last);
        t_ring_result r;
        if (s == LIVE) begin
            r.ok           = ok;
            r.out_byte     = b;
            r.region_start = rs;
            r.region_count = rc;
            r.free_count   = ring_free(s);
            r.last         = last;
            expected_q.push_back(r);
        end
    endtask

    task automatic ring_step(input int s, input logic [2:0] act,
                             input logic [BYTE_W-1:0] din, input logic [LIM_W-1:0] lim);
        logic [AW-1:0]     nxt;
        logic [AW-1:0]     scan;
        logic [BYTE_W-1:0] line_buf [0:LINE_MAX-1];
        logic [BYTE_W-1:0] ch;
        int                run;
        int                cap;
        int                kept;
        int                j;
        bit                found;
        case (act)
            ACT_PUSH: begin
                nxt = ring_next(ring_head[s]);
                if (nxt == ring_tail[s]) begin
                    ring_note(s, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                    ring_mem[s][ring_head[s]] = din;
                    ring_head[s] = nxt;
                    ring_note(s, 1'b1, '0, '0, '0, 1'b1);
                end
            end
            ACT_POP: begin
                if (ring_head[s] == ring_tail[s]) begin
                    ring_note(s, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                    ch = ring_mem[s][ring_tail[s]];
                    ring_tail[s] = ring_next(ring_tail[s]);
                    ring_note(s, 1'b1, ch, '0, '0, 1'b1);
                end
            end
            ACT_LOCK: begin
                if (ring_head[s] == ring_tail[s]) begin
                    ring_note(s, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                    if (ring_head[s] > ring_tail[s])
                        run = int'(ring_head[s]) - int'(ring_tail[s]);
                    else
                        run = DEPTH - int'(ring_tail[s]);
                    if (run > int'(lim))
                        run = int'(lim);
                    j = int'(ring_tail[s]) + run;
                    if (j >= DEPTH)
                        j = 0;
                    ring_pend[s] = AW'(j);
                    ring_note(s, 1'b1, '0, ring_tail[s], IDX_W'(run), 1'b1);
                end
            end
            ACT_UNLOCK: begin
                ring_tail[s] = ring_pend[s];
                ring_note(s, 1'b1, '0, '0, '0, 1'b1);
            end
            ACT_LINE: begin
                cap = (lim == 0) ? 0 : int'(lim) - 1;
                if (cap > LINE_MAX - 1)
                    cap = LINE_MAX - 1;
                scan  = ring_tail[s];
                kept  = 0;
                found = 1'b0;
                while (scan != ring_head[s] && !found) begin
                    ch   = ring_mem[s][scan];
                    scan = ring_next(scan);
                    if (ch == NEWLINE) begin
                        found = 1'b1;
                    end else if (kept < cap) begin
                        line_buf[kept] = ch;
                        kept++;
                    end
                end
                if (found) begin
                    ring_tail[s] = scan;
                    for (j = 0; j < kept; j++)
                        ring_note(s, 1'b1, line_buf[j], '0, '0, 1'b0);
                    ring_note(s, 1'b1, NEWLINE, '0, '0, 1'b1);
                end else begin
                    ring_note(s, 1'b0, '0, '0, '0, 1'b1);
                end
            end
            ACT_CLEAR: begin
                ring_clear(s);
                ring_note(s, 1'b1, '0, '0, '0, 1'b1);
            end
            default: begin
                ring_note(s, 1'b0, '0, '0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic add_word(input logic [2:0] act, input logic [BYTE_W-1:0] din,
                            input logic [LIM_W-1:0] lim, input bit settle, input bit steady);
        t_ring_word w;
        w.action = act;
        w.data   = din;
        w.limit  = lim;
        w.settle = settle;
        w.steady = steady;
        word_q.push_back(w);
        ring_step(PLAN, act, din, lim);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                ring_step(LIVE, cur_word.action, cur_word.data, cur_word.limit);
            if (!i_in_valid || o_in_ready) begin
                if (word_q.size() != 0 &&
                    (!word_q[0].settle || (expected_q.size() == 0 && !i_in_valid)) &&
                    (word_q[0].steady || $urandom_range(99) >= 32)) begin
                    cur_word = word_q.pop_front();
                    i_action   <= cur_word.action;
                    i_data_in  <= cur_word.data;
                    i_limit    <= cur_word.limit;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_ok !== want.ok)
                        report_mismatch("ok", o_ok, want.ok);
                    if (o_out_byte !== want.out_byte)
                        report_mismatch("out_byte", o_out_byte, want.out_byte);
                    if (o_region_start !== want.region_start)
                        report_mismatch("region_start", o_region_start, want.region_start);
                    if (o_region_count !== want.region_count)
                        report_mismatch("region_count", o_region_count, want.region_count);
                    if (o_free_count !== want.free_count)
                        report_mismatch("free_count", o_free_count, want.free_count);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!stall_done && results_seen >= 100) begin
                stall_done = 1'b1;
                stall_left = 400;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (results_seen >= 150 && results_seen < 250) ||
                               ($urandom_range(99) >= 32);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            stuck_cycles <= 0;
        else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        int i;
        int r;
        ring_clear(PLAN);
        ring_clear(LIVE);

        // directed: empty buffer, bad actions, line limits, lock edges
        add_word(ACT_UNLOCK, 8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_POP,    8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_LOCK,   8'h00, 11'd5, 1'b0, 1'b0);
        add_word(ACT_LINE,   8'h00, 11'd64, 1'b0, 1'b0);
        add_word(ACT_BAD_A,  8'hFF, 11'h7FF, 1'b0, 1'b0);
        add_word(ACT_BAD_B,  8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'hFF, 11'h7FF, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'h41, 11'd0, 1'b0, 1'b0);
        add_word(ACT_PUSH,   NEWLINE, 11'd0, 1'b0, 1'b0);
        add_word(ACT_LINE,   8'h00, 11'd1024, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'h55, 11'd0, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'hAA, 11'd0, 1'b0, 1'b0);
        add_word(ACT_PUSH,   NEWLINE, 11'd0, 1'b0, 1'b0);
        add_word(ACT_LINE,   8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'h01, 11'd0, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'h02, 11'd0, 1'b0, 1'b0);
        add_word(ACT_PUSH,   NEWLINE, 11'd0, 1'b0, 1'b0);
        add_word(ACT_LINE,   8'h00, 11'd2, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'h07, 11'd0, 1'b0, 1'b0);
        add_word(ACT_LINE,   8'h00, 11'h7FF, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'h08, 11'd0, 1'b0, 1'b0);
        add_word(ACT_POP,    8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_LOCK,   8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_UNLOCK, 8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_LOCK,   8'h00, 11'h7FF, 1'b0, 1'b0);
        add_word(ACT_UNLOCK, 8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_PUSH,   8'h12, 11'd0, 1'b0, 1'b0);
        add_word(ACT_CLEAR,  8'h00, 11'd0, 1'b0, 1'b0);
        add_word(ACT_UNLOCK, 8'h00, 11'd0, 1'b0, 1'b0);

        for (i = 0; i < RANDOM_WORDS; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                add_word(ACT_PUSH, line_byte(6), LIM_W'($urandom_range(2047)),
                         i == 150, i >= 60 && i < 130);
            end else if (r < 57) begin
                add_word(ACT_POP, BYTE_W'($urandom_range(255)), LIM_W'($urandom_range(2047)),
                         i == 150, i >= 60 && i < 130);
            end else if (r < 72) begin
                add_word(ACT_LINE, BYTE_W'($urandom_range(255)),
                         ($urandom_range(3) == 0) ? LIM_W'($urandom_range(2047))
                                                  : LIM_W'($urandom_range(70)),
                         i == 150, i >= 60 && i < 130);
            end else if (r < 90 && !(r >= 80 && unlock_safe())) begin
                add_word(ACT_LOCK, BYTE_W'($urandom_range(255)),
                         ($urandom_range(1) == 0) ? LIM_W'($urandom_range(2047))
                                                  : LIM_W'($urandom_range(8)),
                         i == 150, i >= 60 && i < 130);
            end else if (r < 90) begin
                add_word(ACT_UNLOCK, BYTE_W'($urandom_range(255)),
                         LIM_W'($urandom_range(2047)), i == 150, i >= 60 && i < 130);
            end else if (r < 93) begin
                add_word(ACT_CLEAR, BYTE_W'($urandom_range(255)),
                         LIM_W'($urandom_range(2047)), i == 150, i >= 60 && i < 130);
            end else if (r < 96) begin
                add_word(($urandom_range(1) == 0) ? ACT_BAD_A : ACT_BAD_B,
                         BYTE_W'($urandom_range(255)), LIM_W'($urandom_range(2047)),
                         i == 150, i >= 60 && i < 130);
            end else begin
                add_word(ACT_POP, BYTE_W'($urandom_range(255)), LIM_W'($urandom_range(2047)),
                         i == 150, i >= 60 && i < 130);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((word_q.size() != 0 || i_in_valid || expected_q.size() != 0) &&
               stuck_cycles < WATCHDOG)
            @(posedge i_clk);
        if (stuck_cycles >= WATCHDOG)
            report_mismatch("watchdog", stuck_cycles, WATCHDOG);
        else
            repeat (200) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch("missing words", expected_q.size(), 0);

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== byte_ring_buffer_with_line_read_core.f =====
+incdir+rtl
rtl/brb_pkg.sv
rtl/byte_ring_buffer_with_line_read_core.sv
tb/tb_byte_ring_buffer_with_line_read_core.sv
